// ===== hdl/pngdf_pkg.sv =====
// Shared types and constants of the PNG scanline defilter.
// Used by every module under hdl except pngdf_ram; depends on nothing.
`default_nettype none

package pngdf_pkg;

    // Image size limits
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 16384;
    localparam int STORE_DEPTH = MAX_WIDTH * 4;

    // Derived widths
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int COL_W   = $clog2(STORE_DEPTH + 1);
    localparam int WEFF_W  = $clog2(MAX_WIDTH + 1);
    localparam int HEFF_W  = $clog2(MAX_HEIGHT + 1);

    // Configuration registers
    localparam int WCFG_W     = 13;
    localparam int HCFG_W     = 15;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_PIXELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_ROWS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_ALPHA    = 2'd2;

    // Row filter types
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_t;

    // What an accepted request turns into at the reconstruction stage
    typedef enum logic [1:0] {
        ITEM_CLEAR = 2'd0,
        ITEM_PIXEL = 2'd1,
        ITEM_ERROR = 2'd2
    } item_kind_t;

    typedef struct packed {
        item_kind_t        kind;
        filter_t           filt;
        logic [BYTE_W-1:0] data;
        logic              up_zero;
        logic              row_end;
        logic              image_end;
        logic [ADDR_W-1:0] addr;
    } item_t;

endpackage

`default_nettype wire

// ===== hdl/pngdf_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// Standalone; no package dependency.
`default_nettype none

module pngdf_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port, hold data between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/pngdf_ctrl.sv =====
// Stream sequencer: configuration registers, row and column counters,
// line store read issue and the request register feeding reconstruction.
// Depends on pngdf_pkg.
`default_nettype none

module pngdf_ctrl (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [pngdf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pngdf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                               stream_valid,
    output logic                                    stream_ready,
    input  wire logic [pngdf_pkg::BYTE_W-1:0]       stream_byte,
    input  wire logic                               s1_advance,
    output logic                                    item_valid,
    output pngdf_pkg::item_t                        item,
    output logic                                    rd_en,
    output logic [pngdf_pkg::ADDR_W-1:0]            rd_addr,
    output logic                                    has_alpha
);

    localparam int COL_W  = pngdf_pkg::COL_W;
    localparam int WEFF_W = pngdf_pkg::WEFF_W;
    localparam int HEFF_W = pngdf_pkg::HEFF_W;
    localparam int RW1    = HEFF_W + 1;

    logic [pngdf_pkg::WCFG_W-1:0] width_reg;
    logic [pngdf_pkg::HCFG_W-1:0] height_reg;
    logic                         alpha_reg;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [HEFF_W-1:0] row_reg, row_next;
    logic              discard_reg, discard_next;
    pngdf_pkg::filter_t filt_reg, filt_next;
    logic              item_valid_reg, item_valid_next;
    pngdf_pkg::item_t  item_reg, item_next;

    logic [WEFF_W-1:0] weff;
    logic [HEFF_W-1:0] heff;
    logic [COL_W-1:0]  stride;
    logic [COL_W-1:0]  col_dec;
    logic              accept;
    logic              col_at_end;
    logic              last_row;
    logic [COL_W-1:0]  adv_col;
    logic [HEFF_W-1:0] adv_row;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= pngdf_pkg::WCFG_W'(1);
            height_reg <= pngdf_pkg::HCFG_W'(1);
            alpha_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pngdf_pkg::CFG_WIDTH_PIXELS: width_reg  <= cfg_data[pngdf_pkg::WCFG_W-1:0];
                pngdf_pkg::CFG_HEIGHT_ROWS:  height_reg <= cfg_data[pngdf_pkg::HCFG_W-1:0];
                pngdf_pkg::CFG_HAS_ALPHA:    alpha_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Clamp width and height, derive row length in bytes
    always_comb
    begin
        if (width_reg == '0)
            weff = WEFF_W'(1);
        else if (32'(width_reg) > pngdf_pkg::MAX_WIDTH)
            weff = WEFF_W'(pngdf_pkg::MAX_WIDTH);
        else
            weff = WEFF_W'(width_reg);

        if (height_reg == '0)
            heff = HEFF_W'(1);
        else if (32'(height_reg) > pngdf_pkg::MAX_HEIGHT)
            heff = HEFF_W'(pngdf_pkg::MAX_HEIGHT);
        else
            heff = HEFF_W'(height_reg);

        if (alpha_reg)
            stride = COL_W'({weff, 2'b00});
        else
            stride = COL_W'({weff, 1'b0}) + COL_W'(weff);
    end

    assign accept       = stream_valid && stream_ready;
    assign stream_ready = !item_valid_reg || s1_advance;

    // Position after the current pixel byte
    assign col_at_end = (col_reg >= stride);
    assign last_row   = ((RW1'(row_reg) + RW1'(1)) >= RW1'(heff));
    assign adv_col    = col_at_end ? '0 : col_reg + COL_W'(1);
    assign adv_row    = col_at_end ? (last_row ? '0 : row_reg + HEFF_W'(1)) : row_reg;
    assign col_dec    = col_reg - COL_W'(1);

    // Sequence filter bytes, pixel bytes and discarded bytes
    always_comb
    begin
        col_next        = col_reg;
        row_next        = row_reg;
        discard_next    = discard_reg;
        filt_next       = filt_reg;
        item_valid_next = item_valid_reg;
        item_next       = item_reg;

        if (s1_advance)
            item_valid_next = 1'b0;

        if (accept)
        begin
            item_valid_next     = 1'b0;
            item_next.kind      = pngdf_pkg::ITEM_PIXEL;
            item_next.filt      = filt_reg;
            item_next.data      = stream_byte;
            item_next.up_zero   = (row_reg == '0);
            item_next.row_end   = col_at_end;
            item_next.image_end = col_at_end && last_row;
            item_next.addr      = col_dec[pngdf_pkg::ADDR_W-1:0];

            if (discard_reg)
            begin
                if (col_reg == '0)
                begin
                    col_next = COL_W'(1);
                end
                else
                begin
                    col_next = adv_col;
                    row_next = adv_row;
                    if (col_at_end && last_row)
                        discard_next = 1'b0;
                end
            end
            else if (col_reg == '0)
            begin
                col_next        = COL_W'(1);
                item_valid_next = 1'b1;
                if (stream_byte > pngdf_pkg::BYTE_W'(pngdf_pkg::FILT_PAETH))
                begin
                    discard_next   = 1'b1;
                    item_next.kind = pngdf_pkg::ITEM_ERROR;
                end
                else
                begin
                    filt_next      = pngdf_pkg::filter_t'(stream_byte[2:0]);
                    item_next.kind = pngdf_pkg::ITEM_CLEAR;
                end
            end
            else
            begin
                item_valid_next = 1'b1;
                col_next        = adv_col;
                row_next        = adv_row;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            discard_reg    <= 1'b0;
            filt_reg       <= pngdf_pkg::FILT_NONE;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            discard_reg    <= discard_next;
            filt_reg       <= filt_next;
            item_valid_reg <= item_valid_next;
        end
    end

    // Request payload
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    // Read the prior row byte for every pixel request
    assign rd_en      = accept && !discard_reg && (col_reg != '0);
    assign rd_addr    = col_dec[pngdf_pkg::ADDR_W-1:0];
    assign item_valid = item_valid_reg;
    assign item       = item_reg;
    assign has_alpha  = alpha_reg;

`ifndef NO_ASSERTIONS
    a_stall_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        !stream_ready |-> item_valid_reg)
        else $error("input stalled with empty request register");

    a_discard_no_item: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && discard_reg) |=> !item_valid_reg)
        else $error("discarded byte produced a request");

    a_pixel_reads: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> (item_valid_reg && item_reg.kind == pngdf_pkg::ITEM_PIXEL))
        else $error("line store read without pixel request");
`endif

endmodule

`default_nettype wire

// ===== hdl/pngdf_recon.sv =====
// Reconstruction stage: filter prediction, left/upper-left pixel history,
// line store write-back and the output register.
// Depends on pngdf_pkg.
`default_nettype none

module pngdf_recon (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    input  wire pngdf_pkg::item_t               item,
    input  wire logic [pngdf_pkg::BYTE_W-1:0]   rd_data,
    input  wire logic                           has_alpha,
    output logic                                s1_advance,
    output logic                                wr_en,
    output logic [pngdf_pkg::ADDR_W-1:0]        wr_addr,
    output logic [pngdf_pkg::BYTE_W-1:0]        wr_data,
    output logic                                pixel_valid,
    input  wire logic                           pixel_ready,
    output logic [pngdf_pkg::BYTE_W-1:0]        pixel_byte,
    output logic                                row_end,
    output logic                                image_end,
    output logic                                bad_filter
);

    localparam int BW = pngdf_pkg::BYTE_W;

    logic [BW-1:0] left_reg   [4];
    logic [BW-1:0] upleft_reg [4];

    logic          pixel_valid_reg;
    logic [BW-1:0] pixel_byte_reg;
    logic          row_end_reg;
    logic          image_end_reg;
    logic          bad_filter_reg;

    logic [1:0]    sel;
    logic [BW-1:0] left;
    logic [BW-1:0] upleft;
    logic [BW-1:0] up;
    logic [BW-1:0] pred;
    logic [BW-1:0] res;
    logic [BW:0]   avg_sum;
    logic          fire;
    logic          is_pixel;
    logic          is_error;

    logic signed [BW+1:0] da, db, dc;
    logic        [BW+1:0] pa, pb, pc;
    logic        [BW-1:0] paeth;

    // Pick neighbors one pixel back
    assign sel    = has_alpha ? 2'd3 : 2'd2;
    assign left   = left_reg[sel];
    assign upleft = upleft_reg[sel];
    assign up     = item.up_zero ? '0 : rd_data;

    // Paeth predictor: distances of a+b-c to a, b and c
    always_comb
    begin
        da = $signed({2'b00, up}) - $signed({2'b00, upleft});
        db = $signed({2'b00, left}) - $signed({2'b00, upleft});
        dc = $signed({2'b00, left}) + $signed({2'b00, up}) - $signed({1'b0, upleft, 1'b0});
        pa = da[BW+1] ? 10'(-da) : 10'(da);
        pb = db[BW+1] ? 10'(-db) : 10'(db);
        pc = dc[BW+1] ? 10'(-dc) : 10'(dc);
        if (pa <= pb && pa <= pc)
            paeth = left;
        else if (pb <= pc)
            paeth = up;
        else
            paeth = upleft;
    end

    assign avg_sum = {1'b0, left} + {1'b0, up};

    // Prediction by row filter
    always_comb
    begin
        case (item.filt)
            pngdf_pkg::FILT_SUB:   pred = left;
            pngdf_pkg::FILT_UP:    pred = up;
            pngdf_pkg::FILT_AVG:   pred = avg_sum[BW:1];
            pngdf_pkg::FILT_PAETH: pred = paeth;
            default:               pred = '0;
        endcase
    end

    assign res        = item.data + pred;
    assign s1_advance = !pixel_valid_reg || pixel_ready;
    assign fire       = s1_advance && item_valid;
    assign is_pixel   = (item.kind == pngdf_pkg::ITEM_PIXEL);
    assign is_error   = (item.kind == pngdf_pkg::ITEM_ERROR);

    // Write the restored byte back for the next row
    assign wr_en   = fire && is_pixel;
    assign wr_addr = item.addr;
    assign wr_data = res;

    // Shift pixel history; clear it at each row start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                left_reg[i]   <= '0;
                upleft_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            case (item.kind)
                pngdf_pkg::ITEM_PIXEL:
                begin
                    for (int i = 3; i > 0; i--)
                    begin
                        left_reg[i]   <= left_reg[i-1];
                        upleft_reg[i] <= upleft_reg[i-1];
                    end
                    left_reg[0]   <= res;
                    upleft_reg[0] <= up;
                end
                pngdf_pkg::ITEM_CLEAR, pngdf_pkg::ITEM_ERROR:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        left_reg[i]   <= '0;
                        upleft_reg[i] <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pixel_valid_reg <= 1'b0;
        else if (s1_advance)
            pixel_valid_reg <= item_valid && (is_pixel || is_error);
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pixel_byte_reg <= is_pixel ? res : '0;
            row_end_reg    <= is_pixel && item.row_end;
            image_end_reg  <= is_pixel && item.image_end;
            bad_filter_reg <= is_error;
        end
    end

    assign pixel_valid = pixel_valid_reg;
    assign pixel_byte  = pixel_byte_reg;
    assign row_end     = row_end_reg;
    assign image_end   = image_end_reg;
    assign bad_filter  = bad_filter_reg;

`ifndef NO_ASSERTIONS
    a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid_reg && bad_filter_reg) |->
            (pixel_byte_reg == '0 && !row_end_reg && !image_end_reg))
        else $error("error result carries pixel data or end flags");

    a_image_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid_reg && image_end_reg) |-> row_end_reg)
        else $error("image end without row end");

    a_stalled_read_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !s1_advance) |=> $stable(rd_data))
        else $error("line store data changed under a stalled request");
`endif

endmodule

`default_nettype wire

// ===== hdl/png_scanline_defilter_unit.sv =====
// PNG scanline defilter, 8-bit RGB/RGBA: accepts the inflated stream one byte
// per cycle unless stalled and emits restored pixel bytes. Line store: each
// pixel reads when taken and writes back from the request register.
//
// Input channel: stream_valid/stream_ready/stream_byte, one request per byte.
// Each row opens with a filter byte that gives no result; a filter byte
// above 4 gives one result with bad_filter set, and the rest of that image
// is then taken and dropped before row 0 is expected again.
// Output channel: pixel_valid/pixel_ready with pixel_byte, row_end,
// image_end and bad_filter.
// Path: an accepted byte passes the request register, then the output
// register, which holds its result until pixel_ready takes it.
// Throughput: one byte per cycle while the output is not stalled, set by the
// single line store read and write per byte.
// Stall: the output register plus one request register hold results while
// pixel_ready is low; stream_ready falls once both are full.
// Configuration: cfg_we/cfg_index/cfg_data; the user writes these only while
// idle, the block does not enforce it. Reset: counters, pixel history and
// flags clear; the line store is not cleared and needs no clearing pass, since row 0 ignores what it reads.
`default_nettype none

module png_scanline_defilter_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [pngdf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pngdf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                               stream_valid,
    output logic                                    stream_ready,
    input  wire logic [pngdf_pkg::BYTE_W-1:0]       stream_byte,
    output logic                                    pixel_valid,
    input  wire logic                               pixel_ready,
    output logic [pngdf_pkg::BYTE_W-1:0]            pixel_byte,
    output logic                                    row_end,
    output logic                                    image_end,
    output logic                                    bad_filter
);

    logic                             s1_advance;
    logic                             item_valid;
    pngdf_pkg::item_t                 item;
    logic                             rd_en;
    logic [pngdf_pkg::ADDR_W-1:0]     rd_addr;
    logic [pngdf_pkg::BYTE_W-1:0]     rd_data;
    logic                             wr_en;
    logic [pngdf_pkg::ADDR_W-1:0]     wr_addr;
    logic [pngdf_pkg::BYTE_W-1:0]     wr_data;
    logic                             has_alpha;

    // Sequencer and read issue
    pngdf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .stream_valid (stream_valid),
        .stream_ready (stream_ready),
        .stream_byte  (stream_byte),
        .s1_advance   (s1_advance),
        .item_valid   (item_valid),
        .item         (item),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .has_alpha    (has_alpha)
    );

    // Prior row line store
    pngdf_ram #(
        .WIDTH (pngdf_pkg::BYTE_W),
        .DEPTH (pngdf_pkg::STORE_DEPTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Reconstruction and output register
    pngdf_recon u_recon (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item        (item),
        .rd_data     (rd_data),
        .has_alpha   (has_alpha),
        .s1_advance  (s1_advance),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_byte  (pixel_byte),
        .row_end     (row_end),
        .image_end   (image_end),
        .bad_filter  (bad_filter)
    );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Testbench of png_scanline_defilter_unit: streams filtered PNG rows in, and
// checks each restored byte and its row/image/error flags against a predictor.
// Depends on hdl/pngdf_pkg.sv and hdl/png_scanline_defilter_unit.sv.

module testbench;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 5000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [pngdf_pkg::BYTE_W-1:0] pixel_byte;
        logic                         row_end;
        logic                         image_end;
        logic                         bad_filter;
    } restored_t;

    // One stream request; drain makes the sender wait for all results first
    typedef struct packed {
        logic                         drain;
        logic [pngdf_pkg::BYTE_W-1:0] value;
    } stream_req_t;

    logic                             clk          = 1'b0;
    logic                             rst_n        = 1'b0;
    logic                             cfg_we       = 1'b0;
    logic [pngdf_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [pngdf_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
    logic                             stream_valid = 1'b0;
    logic                             stream_ready;
    logic [pngdf_pkg::BYTE_W-1:0]     stream_byte  = '0;
    logic                             pixel_valid;
    logic                             pixel_ready  = 1'b0;
    logic [pngdf_pkg::BYTE_W-1:0]     pixel_byte;
    logic                             row_end;
    logic                             image_end;
    logic                             bad_filter;

    stream_req_t pending_bytes[$];
    restored_t   expected_pixels[$];

    int gap_pct      = 0;
    int stall_pct    = 0;
    bit hold_go      = 1'b0;
    bit hold_done    = 1'b0;
    int gap_left     = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int failures     = 0;

    // Predictor state: line copy, pixel history, position and settings
    logic [pngdf_pkg::BYTE_W-1:0] line_copy [pngdf_pkg::STORE_DEPTH];
    logic [pngdf_pkg::BYTE_W-1:0] left_hist [4];
    logic [pngdf_pkg::BYTE_W-1:0] upleft_hist [4];
    pngdf_pkg::filter_t           row_filt   = pngdf_pkg::FILT_NONE;
    int unsigned                  col_pos    = 0;
    int unsigned                  row_pos    = 0;
    bit                           skipping   = 1'b0;
    logic [pngdf_pkg::WCFG_W-1:0] width_reg  = pngdf_pkg::WCFG_W'(1);
    logic [pngdf_pkg::HCFG_W-1:0] height_reg = pngdf_pkg::HCFG_W'(1);
    logic                         alpha_reg  = 1'b0;

    png_scanline_defilter_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .stream_valid (stream_valid),
        .stream_ready (stream_ready),
        .stream_byte  (stream_byte),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel_byte   (pixel_byte),
        .row_end      (row_end),
        .image_end    (image_end),
        .bad_filter   (bad_filter)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Zero acts as one, anything above the top acts as the top
    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned top);
        return (v == 0) ? 1 : ((v > top) ? top : v);
    endfunction

    function automatic bit count_failure();
        failures++;
        return (failures <= REPORT_LIMIT);
    endfunction

    // Move past the current byte position; flag row and image end
    task automatic step_position(output bit re, output bit ie);
        int unsigned stride;
        stride = clamp_dim(32'(width_reg), pngdf_pkg::MAX_WIDTH) * (alpha_reg ? 4 : 3);
        re = 1'b0;
        ie = 1'b0;
        if (col_pos >= stride)
        begin
            re = 1'b1;
            col_pos = 0;
            if (row_pos + 1 >= clamp_dim(32'(height_reg), pngdf_pkg::MAX_HEIGHT))
            begin
                ie = 1'b1;
                row_pos = 0;
                skipping = 1'b0;
            end
            else
                row_pos++;
        end
        else
            col_pos++;
    endtask

    // Work out what one accepted stream byte produces
    task automatic defilter_predict(input logic [pngdf_pkg::BYTE_W-1:0] v, output bit has_out,
                                    output restored_t r);
        logic [1:0] sel;
        logic [pngdf_pkg::ADDR_W-1:0] idx;
        int i;
        int p, pa, pb, pc;
        logic [pngdf_pkg::BYTE_W-1:0] left, upleft, up, pred;
        bit re, ie;
        has_out = 1'b0;
        r = '0;
        sel = alpha_reg ? 2'd3 : 2'd2;
        if (skipping)
        begin
            // drop the rest of an aborted image
            if (col_pos == 0)
                col_pos = 1;
            else
                step_position(re, ie);
        end
        else if (col_pos == 0)
        begin
            // filter byte: clear history, latch the filter or abort
            for (i = 0; i < 4; i++)
            begin
                left_hist[i] = '0;
                upleft_hist[i] = '0;
            end
            col_pos = 1;
            if (v > 4)
            begin
                skipping = 1'b1;
                has_out = 1'b1;
                r.bad_filter = 1'b1;
            end
            else
                row_filt = pngdf_pkg::filter_t'(v[2:0]);
        end
        else
        begin
            idx = pngdf_pkg::ADDR_W'((col_pos - 1 < pngdf_pkg::STORE_DEPTH) ?
                                     col_pos - 1 : pngdf_pkg::STORE_DEPTH - 1);
            left = left_hist[sel];
            upleft = upleft_hist[sel];
            up = (row_pos == 0) ? '0 : line_copy[idx];
            case (row_filt)
                pngdf_pkg::FILT_SUB:
                    pred = left;
                pngdf_pkg::FILT_UP:
                    pred = up;
                pngdf_pkg::FILT_AVG:
                begin
                    p = int'(left) + int'(up);
                    pred = p[8:1];
                end
                pngdf_pkg::FILT_PAETH:
                begin
                    p = int'(left) + int'(up) - int'(upleft);
                    pa = p - int'(left);
                    pb = p - int'(up);
                    pc = p - int'(upleft);
                    if (pa < 0) pa = -pa;
                    if (pb < 0) pb = -pb;
                    if (pc < 0) pc = -pc;
                    if (pa <= pb && pa <= pc)
                        pred = left;
                    else if (pb <= pc)
                        pred = up;
                    else
                        pred = upleft;
                end
                default:
                    pred = '0;
            endcase
            r.pixel_byte = v + pred;
            for (i = 3; i > 0; i--)
            begin
                left_hist[i] = left_hist[i-1];
                upleft_hist[i] = upleft_hist[i-1];
            end
            left_hist[0] = r.pixel_byte;
            upleft_hist[0] = up;
            line_copy[idx] = r.pixel_byte;
            step_position(re, ie);
            r.row_end = re;
            r.image_end = ie;
            has_out = 1'b1;
        end
    endtask

    // Sender: present queued requests, with random idle bursts
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stream_valid <= 1'b0;
            gap_left = 0;
        end
        else if (!stream_valid || stream_ready)
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                stream_valid <= 1'b0;
            end
            else if (pending_bytes.size() == 0 ||
                     (pending_bytes[0].drain &&
                      (stream_valid || expected_pixels.size() != 0)))
                stream_valid <= 1'b0;
            else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
            begin
                gap_left = int'($urandom_range(0, 15));
                stream_valid <= 1'b0;
            end
            else
            begin
                stream_byte <= pending_bytes[0].value;
                stream_valid <= 1'b1;
                void'(pending_bytes.pop_front());
            end
        end
    end

    // Receiver: one long hold-off on request, otherwise random stall bursts
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pixel_ready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            pixel_ready <= 1'b0;
        end
        else if (hold_go && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            pixel_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            pixel_ready <= 1'b0;
        end
        else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left = int'($urandom_range(0, 15));
            pixel_ready <= 1'b0;
        end
        else
            pixel_ready <= 1'b1;
    end

    // Monitor: check accepted results, predict accepted requests
    always @(posedge clk)
    begin : check_results
        restored_t want;
        restored_t got;
        bit produced;
        if (rst_n)
        begin
            if (pixel_valid && pixel_ready)
            begin
                got = {pixel_byte, row_end, image_end, bad_filter};
                if (expected_pixels.size() == 0)
                begin
                    if (count_failure())
                        $display("unexpected result: byte %02h row_end %0b image_end %0b bad %0b",
                                 got.pixel_byte, got.row_end, got.image_end, got.bad_filter);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.pixel_byte !== want.pixel_byte || got.row_end !== want.row_end ||
                        got.image_end !== want.image_end || got.bad_filter !== want.bad_filter)
                    begin
                        if (count_failure())
                            $display("mismatch: expected %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                                     want.pixel_byte, want.row_end, want.image_end,
                                     want.bad_filter, got.pixel_byte, got.row_end,
                                     got.image_end, got.bad_filter);
                    end
                end
            end
            if (stream_valid && stream_ready)
            begin
                defilter_predict(stream_byte, produced, want);
                if (produced)
                    expected_pixels.push_back(want);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((stream_valid && stream_ready) || (pixel_valid && pixel_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Write one register; the predictor takes the same value
    task automatic write_reg(input logic [pngdf_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[pngdf_pkg::CFG_DATA_W-1:0];
        case (idx)
            pngdf_pkg::CFG_WIDTH_PIXELS: width_reg = val[pngdf_pkg::WCFG_W-1:0];
            pngdf_pkg::CFG_HEIGHT_ROWS:  height_reg = val[pngdf_pkg::HCFG_W-1:0];
            pngdf_pkg::CFG_HAS_ALPHA:    alpha_reg = val[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every request is taken and every result is in, then settle
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || stream_valid || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Queue one image; a bad filter byte aborts it and the rest is dropped
    task automatic queue_image(input int stride, input int rows, input int bad_pct,
                               input bit drain_first, inout int counted);
        stream_req_t req;
        bit aborted;
        int r, k;
        aborted = 1'b0;
        for (r = 0; r < rows; r++)
        begin
            req.drain = drain_first && (r == 0);
            if (aborted)
                req.value = pngdf_pkg::BYTE_W'($urandom_range(0, 255));
            else if ($urandom_range(0, 99) < bad_pct)
            begin
                req.value = $urandom_range(0, 1) ? pngdf_pkg::BYTE_W'($urandom_range(5, 7)) :
                                                   pngdf_pkg::BYTE_W'($urandom_range(5, 255));
                aborted = 1'b1;
                counted++;
            end
            else
            begin
                req.value = pngdf_pkg::BYTE_W'($urandom_range(pngdf_pkg::FILT_NONE,
                                                              pngdf_pkg::FILT_PAETH));
                counted++;
            end
            pending_bytes.push_back(req);
            req.drain = 1'b0;
            for (k = 0; k < stride; k++)
            begin
                // lean on the extremes to hit wrap-around and Paeth ties
                case ($urandom_range(0, 7))
                    0:       req.value = 8'h00;
                    1:       req.value = 8'hFF;
                    default: req.value = pngdf_pkg::BYTE_W'($urandom_range(0, 255));
                endcase
                pending_bytes.push_back(req);
                if (!aborted)
                    counted++;
            end
        end
    endtask

    // One setting: write all registers, then whole images until the target
    task automatic run_phase(input int unsigned w, input int unsigned h, input bit a,
                             input int target, input int g, input int s, input int bad,
                             input bit hold);
        int counted;
        int stride;
        int rows;
        bit drained;
        bit drain_next;
        write_reg(pngdf_pkg::CFG_WIDTH_PIXELS, w);
        write_reg(pngdf_pkg::CFG_HEIGHT_ROWS, h);
        write_reg(pngdf_pkg::CFG_HAS_ALPHA, 32'(a));
        stride = clamp_dim(w, pngdf_pkg::MAX_WIDTH) * (a ? 4 : 3);
        rows = clamp_dim(h, pngdf_pkg::MAX_HEIGHT);
        @(negedge clk);
        gap_pct = g;
        stall_pct = s;
        if (hold)
            hold_go = 1'b1;
        counted = 0;
        drained = 1'b0;
        while (counted < target)
        begin
            drain_next = !drained && (counted >= target / 2);
            if (drain_next)
                drained = 1'b1;
            queue_image(stride, rows, bad, drain_next, counted);
        end
        wait_idle();
    endtask

    initial
    begin : main_sequence
        logic [pngdf_pkg::BYTE_W-1:0] opening [32];
        stream_req_t req;
        int k;
        // Paeth then Average; None then Up; Sub then a bad filter on the
        // last row; a bad filter of all ones on row 0 with the rest dropped
        opening = '{8'h04, 8'h00, 8'hFF, 8'h80, 8'h03, 8'hFF, 8'hFF, 8'h01,
                    8'h00, 8'h7F, 8'h80, 8'hFF, 8'h02, 8'hFF, 8'h01, 8'h00,
                    8'h01, 8'hFF, 8'h00, 8'h55, 8'h05, 8'hAA, 8'h55, 8'hFF,
                    8'hFF, 8'h00, 8'h11, 8'h22, 8'h06, 8'h33, 8'h44, 8'h55};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows: one pixel wide RGB, two rows per image
        write_reg(pngdf_pkg::CFG_WIDTH_PIXELS, 1);
        write_reg(pngdf_pkg::CFG_HEIGHT_ROWS, 2);
        write_reg(pngdf_pkg::CFG_HAS_ALPHA, 0);
        @(negedge clk);
        gap_pct = 10;
        stall_pct = 10;
        req.drain = 1'b0;
        for (k = 0; k < 32; k++)
        begin
            req.value = opening[k];
            pending_bytes.push_back(req);
        end
        wait_idle();

        // Random images: small sizes, a zero-size setting and one wider RGBA image
        run_phase(3, 4, 0, 170, 10, 10, 5, 1'b0);
        run_phase(2, 3, 1, 170, 0, 0, 5, 1'b1);
        run_phase(0, 0, 1, 170, 25, 25, 5, 1'b0);
        run_phase(5, 2, 1, 170, 5, 30, 8, 1'b0);
        run_phase(16, 2, 1, 1, 10, 10, 0, 1'b0);
        run_phase(7, 5, 0, 170, 0, 0, 5, 1'b0);

        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
